FILE: src/qslp_pkg.sv
// ----------------------------------------------------------------------------
// qslp_pkg: shared types and constants for the quaternion slerp unit
// Fixed-point constants, CORDIC arctangent table and the sideband records
// that travel with each item through the pipeline.
// ----------------------------------------------------------------------------
package qslp_pkg;

	// default CORDIC iteration count
	localparam int CORDIC_STEPS_DEF = 16;

	// datapath width of the CORDIC x, y and z registers
	localparam int CORDIC_W = 36;

	// width of sin w, the divider denominator
	localparam int ROOT_W = 31;

	// width of a scale factor, range [-2^31, 2^31]
	localparam int SCALE_W = 33;

	// CORDIC start value, 1/gain in Q30
	localparam logic [29:0] GAIN_Q30 = 30'd652032874;

	// reset value of the near margin register
	localparam logic [10:0] MARGIN_RESET = 11'd11;

	// per-item payload that rides along the arithmetic
	typedef struct packed {
		logic [3:0][15:0] p;
		logic [3:0][16:0] qn;
		logic             neg;
	} blk_t;

	// per-item controls for the final blend
	typedef struct packed {
		logic [15:0] t;
		logic        lin;
	} ctl_t;

	// arctangent of 2^-i in Q30, truncated
	function automatic logic [29:0] atan_q30(input int unsigned i);
		logic [29:0] v;
		case (i)
			0:  v = 30'd843314856;
			1:  v = 30'd497837829;
			2:  v = 30'd263043836;
			3:  v = 30'd133525158;
			4:  v = 30'd67021686;
			5:  v = 30'd33543515;
			6:  v = 30'd16775850;
			7:  v = 30'd8388437;
			8:  v = 30'd4194282;
			9:  v = 30'd2097149;
			10: v = 30'd1048575;
			11: v = 30'd524287;
			12: v = 30'd262143;
			13: v = 30'd131071;
			14: v = 30'd65535;
			15: v = 30'd32767;
			16: v = 30'd16383;
			17: v = 30'd8191;
			18: v = 30'd4095;
			19: v = 30'd2047;
			20: v = 30'd1023;
			21: v = 30'd511;
			22: v = 30'd255;
			23: v = 30'd127;
			24: v = 30'd63;
			25: v = 30'd31;
			26: v = 30'd15;
			27: v = 30'd7;
			28: v = 30'd3;
			29: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: src/quaternion_slerp_unit.sv
// ----------------------------------------------------------------------------
// quaternion_slerp_unit: pipelined fixed-point quaternion slerp
// Pipeline: 4 setup stages, 31 square-root stages, two CORDIC chains with
// one angle-split stage between them, 34 divider stages and 2 blend stages.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while the output item waits.
// Reset: arst_n clears all valid bits and loads near_margin with 11.
// ----------------------------------------------------------------------------
module quaternion_slerp_unit #(
	parameter int CORDIC_STEPS = qslp_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [10:0]  cfg_wdata,       // near_margin
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// first_c0, first_c1, first_c2, first_c3, second_c0..second_c3, blend
	input  logic [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,    // out_c0, out_c1, out_c2, out_c3
	output logic         m_axis_tuser     // second_negated
);

	localparam int DW  = qslp_pkg::CORDIC_W;
	localparam int RW  = qslp_pkg::ROOT_W;
	localparam int SW  = qslp_pkg::SCALE_W;
	localparam int BW  = $bits(qslp_pkg::blk_t);
	localparam int CW  = $bits(qslp_pkg::ctl_t);
	localparam int SQN = 31;

	logic        en;
	logic [10:0] near_margin_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_margin_q <= qslp_pkg::MARGIN_RESET;
		end else if (cfg_wen) begin
			near_margin_q <= cfg_wdata;
		end
	end

	// advance whenever the output register is free or being drained
	logic vld_s7;
	assign en            = !vld_s7 || m_axis_tready;
	assign s_axis_tready = en;

	// ---------------- stage 1: component products ----------------
	logic [3:0][15:0]        p_s1, q_s1;
	logic signed [31:0]      prod_s1 [4];
	logic [15:0]             t_s1;
	logic                    vld_s1;
	logic [15:0]             blend_in;

	assign blend_in = s_axis_tdata[143:128];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_s1
		always_ff @(posedge clk) begin
			if (en) begin
				p_s1[i]    <= s_axis_tdata[16*i +: 16];
				q_s1[i]    <= s_axis_tdata[64 + 16*i +: 16];
				prod_s1[i] <= $signed(s_axis_tdata[16*i +: 16])
				            * $signed(s_axis_tdata[64 + 16*i +: 16]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= (blend_in > 16'd32768) ? 16'd32768 : blend_in;
		end
	end

	// ---------------- stage 2: dot product, shorter arc, branch ----------------
	logic signed [33:0] dot;
	logic               neg;
	logic [32:0]        cosv;
	logic [3:0][16:0]   qn;
	logic [3:0][15:0]   p_s2;
	logic [3:0][16:0]   qn_s2;
	logic [15:0]        t_s2;
	logic [29:0]        cos_s2;
	logic               neg_s2, lin_s2, vld_s2;

	always_comb begin
		dot  = 34'(prod_s1[0]) + 34'(prod_s1[1]) + 34'(prod_s1[2]) + 34'(prod_s1[3]);
		neg  = dot[33];
		cosv = neg ? 33'(-dot) : 33'(dot);
		for (int i = 0; i < 4; i++) begin
			qn[i] = neg ? 17'(-$signed(q_s1[i])) : 17'($signed(q_s1[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2   <= p_s1;
			qn_s2  <= qn;
			t_s2   <= t_s1;
			cos_s2 <= cosv[29:0];
			neg_s2 <= neg;
			// linear blend when 1 - cos does not exceed the margin
			lin_s2 <= (34'(cosv) + 34'(near_margin_q)) >= 34'h0_4000_0000;
		end
	end

	// ---------------- stage 3: cos squared ----------------
	logic [59:0]      sq_s3;
	logic [29:0]      cos_s3;
	qslp_pkg::blk_t   blk_s3;
	qslp_pkg::ctl_t   ctl_s3;
	logic             vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3      <= cos_s2 * cos_s2;
			cos_s3     <= cos_s2;
			blk_s3.p   <= p_s2;
			blk_s3.qn  <= qn_s2;
			blk_s3.neg <= neg_s2;
			ctl_s3.t   <= t_s2;
			ctl_s3.lin <= lin_s2;
		end
	end

	// ---------------- stage 4: 1 - cos^2 ----------------
	logic [60:0]      rem_s4;
	logic [29:0]      cos_s4;
	qslp_pkg::blk_t   blk_s4;
	qslp_pkg::ctl_t   ctl_s4;
	logic             vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s4 <= (61'd1 << 60) - 61'(sq_s3);
			cos_s4 <= cos_s3;
			blk_s4 <= blk_s3;
			ctl_s4 <= ctl_s3;
		end
	end

	// ---------------- square root, one result bit per stage ----------------
	logic [60:0]          sr_rem_s  [SQN+1];
	logic [RW-1:0]        sr_root_s [SQN+1];
	logic [29:0]          sr_cos_s  [SQN+1];
	logic [BW+CW-1:0]     sr_side_s [SQN+1];
	logic                 sr_vld_s  [SQN+1];

	assign sr_rem_s[0]  = rem_s4;
	assign sr_root_s[0] = '0;
	assign sr_cos_s[0]  = cos_s4;
	assign sr_side_s[0] = {blk_s4, ctl_s4};
	assign sr_vld_s[0]  = vld_s4;

	for (genvar j = 0; j < SQN; j++) begin : g_sqrt
		localparam int K = SQN - 1 - j;
		logic [61:0] tst;
		logic        ge;

		// try setting root bit K: (r + 2^K)^2 - r^2 = r*2^(K+1) + 2^(2K)
		always_comb begin
			tst = (62'(sr_root_s[j]) << (K + 1)) + (62'd1 << (2 * K));
			ge  = 62'(sr_rem_s[j]) >= tst;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_vld_s[j+1] <= 1'b0;
			end else if (en) begin
				sr_vld_s[j+1] <= sr_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sr_rem_s[j+1]  <= ge ? sr_rem_s[j] - tst[60:0] : sr_rem_s[j];
				sr_root_s[j+1] <= ge ? sr_root_s[j] | (RW'(1) << K) : sr_root_s[j];
				sr_cos_s[j+1]  <= sr_cos_s[j];
				sr_side_s[j+1] <= sr_side_s[j];
			end
		end
	end

	// ---------------- angle w = atan2(sin w, cos) ----------------
	logic                  ang_vld;
	logic signed [DW-1:0]  ang_w;
	logic [BW+CW+RW-1:0]   ang_tag;

	qslp_cordic #(
		.STEPS  (CORDIC_STEPS),
		.VECTOR (1'b1),
		.TAG_W  (BW + CW + RW)
	) u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sr_vld_s[SQN]),
		.x_in      ($signed(DW'(sr_cos_s[SQN]))),
		.y_in      ($signed(DW'(sr_root_s[SQN]))),
		.z_in      ('0),
		.tag_in    ({sr_side_s[SQN], sr_root_s[SQN]}),
		.out_valid (ang_vld),
		.res_out   (ang_w),
		.tag_out   (ang_tag)
	);

	// ---------------- stage 5: split the angle by t ----------------
	qslp_pkg::ctl_t        ang_ctl;
	logic signed [52:0]    wa_full, wb_full;
	logic signed [DW-1:0]  wa_s5, wb_s5;
	logic [BW+CW-1:0]      side_s5;
	logic [RW-1:0]         root_s5;
	logic                  vld_s5;

	always_comb begin
		ang_ctl = ang_tag[CW+RW-1:RW];
		wa_full = $signed({1'b0, 16'd32768 - ang_ctl.t}) * ang_w;
		wb_full = $signed({1'b0, ang_ctl.t}) * ang_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= ang_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wa_s5   <= DW'(wa_full >>> 15);
			wb_s5   <= DW'(wb_full >>> 15);
			side_s5 <= ang_tag[BW+CW+RW-1:RW];
			root_s5 <= ang_tag[RW-1:0];
		end
	end

	// ---------------- sines of (1-t)w and tw ----------------
	logic                  sa_vld, sb_vld;
	logic signed [DW-1:0]  sin_a, sin_b;
	logic [BW+CW-1:0]      sin_side;
	logic [RW-1:0]         sin_root;

	qslp_cordic #(
		.STEPS  (CORDIC_STEPS),
		.VECTOR (1'b0),
		.TAG_W  (BW + CW)
	) u_sin_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s5),
		.x_in      ($signed(DW'(qslp_pkg::GAIN_Q30))),
		.y_in      ('0),
		.z_in      (wa_s5),
		.tag_in    (side_s5),
		.out_valid (sa_vld),
		.res_out   (sin_a),
		.tag_out   (sin_side)
	);

	qslp_cordic #(
		.STEPS  (CORDIC_STEPS),
		.VECTOR (1'b0),
		.TAG_W  (RW)
	) u_sin_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s5),
		.x_in      ($signed(DW'(qslp_pkg::GAIN_Q30))),
		.y_in      ('0),
		.z_in      (wb_s5),
		.tag_in    (root_s5),
		.out_valid (sb_vld),
		.res_out   (sin_b),
		.tag_out   (sin_root)
	);

	// ---------------- scales: sine / sin w ----------------
	logic                  da_vld, db_vld;
	logic signed [SW-1:0]  scl_a, scl_b;
	logic [BW-1:0]         div_blk;
	logic [CW-1:0]         div_ctl;

	qslp_div #(
		.TAG_W (BW)
	) u_div_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sa_vld),
		.num       (sin_a),
		.den       (sin_root),
		.tag_in    (sin_side[BW+CW-1:CW]),
		.out_valid (da_vld),
		.quo       (scl_a),
		.tag_out   (div_blk)
	);

	qslp_div #(
		.TAG_W (CW)
	) u_div_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sb_vld),
		.num       (sin_b),
		.den       (sin_root),
		.tag_in    (sin_side[CW-1:0]),
		.out_valid (db_vld),
		.quo       (scl_b),
		.tag_out   (div_ctl)
	);

	// ---------------- stage 6: scale products ----------------
	qslp_pkg::blk_t        mb;
	qslp_pkg::ctl_t        mc;
	logic signed [SW-1:0]  sp, sq;
	logic signed [49:0]    pa_s6 [4];
	logic signed [49:0]    pb_s6 [4];
	logic                  neg_s6, vld_s6;

	always_comb begin
		mb = div_blk;
		mc = div_ctl;
		sp = mc.lin ? $signed(SW'({16'd32768 - mc.t, 15'd0})) : scl_a;
		sq = mc.lin ? $signed(SW'({mc.t, 15'd0})) : scl_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= da_vld & db_vld;
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_s6
		always_ff @(posedge clk) begin
			if (en) begin
				pa_s6[i] <= 50'(sp * $signed(mb.p[i]));
				pb_s6[i] <= 50'(sq * $signed(mb.qn[i]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s6 <= mb.neg;
		end
	end

	// ---------------- stage 7: round, shift, saturate; output register ------
	logic [3:0][15:0] out_s7;
	logic             neg_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_s7
		logic signed [50:0] acc;
		logic signed [20:0] shv;

		always_comb begin
			acc = 51'(pa_s6[i]) + 51'(pb_s6[i]) + 51'sd536870912;
			shv = 21'(acc >>> 30);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (shv > 21'sd32767) begin
					out_s7[i] <= 16'h7FFF;
				end else if (shv < -21'sd32768) begin
					out_s7[i] <= 16'h8000;
				end else begin
					out_s7[i] <= shv[15:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s7 <= neg_s6;
		end
	end

	assign m_axis_tvalid = vld_s7;
	assign m_axis_tdata  = out_s7;
	assign m_axis_tuser  = neg_s7;

endmodule

FILE: src/qslp_cordic.sv
// ----------------------------------------------------------------------------
// qslp_cordic: pipelined CORDIC, one iteration per stage
// Vectoring mode returns the accumulated angle z; rotation mode returns y.
// A tag travels alongside so the caller keeps its item data aligned.
// ----------------------------------------------------------------------------
module qslp_cordic #(
	parameter int   STEPS  = qslp_pkg::CORDIC_STEPS_DEF,
	parameter bit   VECTOR = 1'b0,
	parameter int   TAG_W  = 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic signed [qslp_pkg::CORDIC_W-1:0] x_in,
	input  logic signed [qslp_pkg::CORDIC_W-1:0] y_in,
	input  logic signed [qslp_pkg::CORDIC_W-1:0] z_in,
	input  logic        [TAG_W-1:0]              tag_in,
	output logic                                 out_valid,
	output logic signed [qslp_pkg::CORDIC_W-1:0] res_out,
	output logic        [TAG_W-1:0]              tag_out
);

	localparam int DW = qslp_pkg::CORDIC_W;

	logic signed [DW-1:0]    x_s   [STEPS+1];
	logic signed [DW-1:0]    y_s   [STEPS+1];
	logic signed [DW-1:0]    z_s   [STEPS+1];
	logic        [TAG_W-1:0] tag_s [STEPS+1];
	logic                    vld_s [STEPS+1];

	// stage zero is the input
	assign x_s[0]   = x_in;
	assign y_s[0]   = y_in;
	assign z_s[0]   = z_in;
	assign tag_s[0] = tag_in;
	assign vld_s[0] = in_valid;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [DW-1:0] xsh;
		logic signed [DW-1:0] ysh;
		logic signed [DW-1:0] ang;
		logic                 dir;
		logic                 sub;

		// pick the rotation direction from the sign of y or z
		always_comb begin
			xsh = x_s[i] >>> i;
			ysh = y_s[i] >>> i;
			ang = $signed(DW'(qslp_pkg::atan_q30(i)));
			dir = VECTOR ? !y_s[i][DW-1] : !z_s[i][DW-1];
			sub = dir ^ VECTOR;
		end

		// advance one micro-rotation
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1]   <= sub ? x_s[i] - ysh : x_s[i] + ysh;
				y_s[i+1]   <= sub ? y_s[i] + xsh : y_s[i] - xsh;
				z_s[i+1]   <= sub ? z_s[i] - ang : z_s[i] + ang;
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign res_out   = VECTOR ? z_s[STEPS] : y_s[STEPS];
	assign tag_out   = tag_s[STEPS];

endmodule

FILE: src/qslp_div.sv
// ----------------------------------------------------------------------------
// qslp_div: pipelined scale divider
// Computes num * 2^30 / den truncated toward zero, clamped to +-2^31, one
// quotient bit per stage with a restoring compare and subtract.
// ----------------------------------------------------------------------------
module qslp_div #(
	parameter int TAG_W = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [qslp_pkg::CORDIC_W-1:0] num,
	input  logic        [qslp_pkg::ROOT_W-1:0]   den,
	input  logic        [TAG_W-1:0]              tag_in,
	output logic                                out_valid,
	output logic signed [qslp_pkg::SCALE_W-1:0]  quo,
	output logic        [TAG_W-1:0]              tag_out
);

	localparam int NW = qslp_pkg::CORDIC_W;
	localparam int RW = qslp_pkg::ROOT_W;
	localparam int QB = 32;

	logic [63:0]       rem_s [QB+1];
	logic [QB-1:0]     quo_s [QB+1];
	logic [RW-1:0]     den_s [QB+1];
	logic              sgn_s [QB+1];
	logic              ovf_s [QB+1];
	logic [TAG_W-1:0]  tag_s [QB+1];
	logic              vld_s [QB+1];

	logic [NW-1:0]     mag;
	logic [QB-1:0]     qmag;
	logic [QB:0]       qclip;
	logic signed [qslp_pkg::SCALE_W-1:0] res_q;
	logic [TAG_W-1:0]  tag_q;
	logic              vld_q;

	// take the magnitude and flag a quotient at or above 2^32
	assign mag = num[NW-1] ? NW'(-num) : NW'(num);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= 64'(mag) << 30;
			quo_s[0] <= '0;
			den_s[0] <= den;
			sgn_s[0] <= num[NW-1];
			ovf_s[0] <= mag >= NW'({den, 2'b00});
			tag_s[0] <= tag_in;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < QB; j++) begin : g_bit
		localparam int K = QB - 1 - j;
		logic [63:0] dsh;
		logic        ge;

		always_comb begin
			dsh = 64'(den_s[j]) << K;
			ge  = rem_s[j] >= dsh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? rem_s[j] - dsh : rem_s[j];
				quo_s[j+1] <= ge ? quo_s[j] | (QB'(1) << K) : quo_s[j];
				den_s[j+1] <= den_s[j];
				sgn_s[j+1] <= sgn_s[j];
				ovf_s[j+1] <= ovf_s[j];
				tag_s[j+1] <= tag_s[j];
			end
		end
	end

	// clamp and restore the sign
	always_comb begin
		qmag  = quo_s[QB];
		qclip = (ovf_s[QB] || qmag > 32'h8000_0000) ? (QB+1)'(33'h0_8000_0000)
		                                             : (QB+1)'(qmag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= sgn_s[QB] ? -$signed(qclip) : $signed(qclip);
			tag_q <= tag_s[QB];
		end
	end

	assign out_valid = vld_q;
	assign quo       = res_q;
	assign tag_out   = tag_q;

endmodule
